FILE: rtl/iel_pkg.sv
// Package for the indexed insert/erase list.
// Holds field widths, default sizes, opcode, status and sequencer state codes.
// No dependencies.
package iel_pkg;

    localparam int DEPTH_DEF     = 256;
    localparam int WORD_BITS_DEF = 64;

    localparam int OP_W   = 3;
    localparam int POS_W  = 9;
    localparam int WORD_W = 64;
    localparam int STAT_W = 2;
    localparam int HELD_W = 9;

    typedef enum logic [OP_W-1:0] {
        OP_GET    = 3'd0,
        OP_SET    = 3'd1,
        OP_INSERT = 3'd2,
        OP_ERASE  = 3'd3,
        OP_APPEND = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_MOVE,
        S_INS_PUT,
        S_ERA_MOVE,
        S_FINISH
    } state_t;

endpackage

FILE: rtl/iel_if.sv
// Handshake interfaces for the request and response channels of the list.
// Depends on iel_pkg for the field widths.
interface iel_req_if;
    import iel_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] word_in;

    modport source (output valid, output opcode, output position, output word_in,
                    input ready);
    modport sink   (input valid, input opcode, input position, input word_in,
                    output ready);
endinterface

interface iel_rsp_if;
    import iel_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word_out;
    logic [STAT_W-1:0] status;
    logic [HELD_W-1:0] entries_held;

    modport source (output valid, output word_out, output status, output entries_held,
                    input ready);
    modport sink   (input valid, input word_out, input status, input entries_held,
                    output ready);
endinterface

FILE: rtl/iel_mem.sv
// Entry store of the list: one write port and one read port, registered read.
// Depends on iel_pkg for default sizes.
module iel_mem #(
    parameter int DEPTH = iel_pkg::DEPTH_DEF,
    parameter int WIDTH = iel_pkg::WORD_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/iel_ctrl.sv
// Sequencer of the list: decodes a transaction, checks its range, drives the
// entry store through read-modify-write shifts and holds the response register.
// Depends on iel_pkg and the iel_req_if / iel_rsp_if interfaces.
module iel_ctrl #(
    parameter int DEPTH     = iel_pkg::DEPTH_DEF,
    parameter int WORD_BITS = iel_pkg::WORD_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    iel_req_if.sink                  req,
    iel_rsp_if.source                rsp,
    output logic                     mem_wr_en,
    output logic [$clog2(DEPTH)-1:0] mem_wr_addr,
    output logic [WORD_BITS-1:0]     mem_wr_data,
    output logic                     mem_rd_en,
    output logic [$clog2(DEPTH)-1:0] mem_rd_addr,
    input  logic [WORD_BITS-1:0]     mem_rd_data
);
    import iel_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [ADDR_W-1:0]     cursor_reg, cursor_next;
    op_t                   op_reg;
    status_t               stat_reg;
    logic [ADDR_W-1:0]     pos_reg;
    logic [WORD_BITS-1:0]  word_reg;

    logic                  out_valid_reg;
    logic [WORD_W-1:0]     out_word_reg;
    status_t               out_stat_reg;
    logic [HELD_W-1:0]     out_held_reg;

    // Decode of the offered transaction.
    op_t                   in_op;
    logic [CMP_W-1:0]      in_pos_ext;
    logic [CMP_W-1:0]      cnt_ext;
    logic [ADDR_W-1:0]     in_addr;
    logic [CNT_W-1:0]      cnt_m1;
    logic                  is_full;
    status_t               in_stat;
    logic                  in_ok;
    logic                  ins_shift;
    logic                  era_shift;
    logic                  accept;
    logic                  result_load;
    logic [WORD_W-1:0]     result_word;
    logic [CMP_W-1:0]      count_ext;

    assign in_op      = op_t'(req.opcode);
    assign in_pos_ext = CMP_W'(req.position);
    assign cnt_ext    = CMP_W'(count_reg);
    assign in_addr    = in_pos_ext[ADDR_W-1:0];
    assign cnt_m1     = count_reg - CNT_W'(1);
    assign is_full    = (count_reg == CNT_W'(DEPTH));
    assign accept     = req.valid && (state_reg == S_IDLE);

    always_comb
    begin
        in_stat = STAT_OK;
        case (in_op)
            OP_GET, OP_SET, OP_ERASE:
            begin
                if (in_pos_ext >= cnt_ext)
                    in_stat = STAT_RANGE;
            end
            OP_INSERT:
            begin
                if (in_pos_ext > cnt_ext)
                    in_stat = STAT_RANGE;
                else if (is_full)
                    in_stat = STAT_FULL;
            end
            OP_APPEND:
            begin
                if (is_full)
                    in_stat = STAT_FULL;
            end
            default:
            begin
                in_stat = STAT_OK;
            end
        endcase
    end

    assign in_ok     = (in_stat == STAT_OK);
    assign ins_shift = in_ok && (in_op == OP_INSERT) && (in_pos_ext != cnt_ext);
    assign era_shift = in_ok && (in_op == OP_ERASE)
                       && (in_pos_ext != CMP_W'(cnt_m1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (ins_shift)
                        state_next = S_INS_MOVE;
                    else if (era_shift)
                        state_next = S_ERA_MOVE;
                    else
                        state_next = S_FINISH;
                end
            end
            S_INS_MOVE:
            begin
                if (cursor_reg == pos_reg)
                    state_next = S_INS_PUT;
            end
            S_INS_PUT:
            begin
                state_next = S_FINISH;
            end
            S_ERA_MOVE:
            begin
                if (CNT_W'(cursor_reg) == cnt_m1)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory commands, count and cursor updates.
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = req.word_in[WORD_BITS-1:0];
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        result_load = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && in_ok)
                begin
                    case (in_op)
                        OP_GET:
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = in_addr;
                        end
                        OP_SET:
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = in_addr;
                        end
                        OP_INSERT:
                        begin
                            if (ins_shift)
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = cnt_m1[ADDR_W-1:0];
                                cursor_next = cnt_m1[ADDR_W-1:0];
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = in_addr;
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        OP_ERASE:
                        begin
                            if (era_shift)
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = in_addr + ADDR_W'(1);
                                cursor_next = in_addr + ADDR_W'(1);
                            end
                            else
                            begin
                                count_next = cnt_m1;
                            end
                        end
                        OP_APPEND:
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = count_reg[ADDR_W-1:0];
                            count_next  = count_reg + CNT_W'(1);
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            S_INS_MOVE:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = cursor_reg + ADDR_W'(1);
                mem_wr_data = mem_rd_data;
                if (cursor_reg != pos_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = cursor_reg - ADDR_W'(1);
                    cursor_next = cursor_reg - ADDR_W'(1);
                end
            end
            S_INS_PUT:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = pos_reg;
                mem_wr_data = word_reg;
                count_next  = count_reg + CNT_W'(1);
            end
            S_ERA_MOVE:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = cursor_reg - ADDR_W'(1);
                mem_wr_data = mem_rd_data;
                if (CNT_W'(cursor_reg) == cnt_m1)
                begin
                    count_next = cnt_m1;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = cursor_reg + ADDR_W'(1);
                    cursor_next = cursor_reg + ADDR_W'(1);
                end
            end
            S_FINISH:
            begin
                result_load = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                result_load = 1'b0;
            end
        endcase
    end

    // Only a successful get returns a word; the read data is still held.
    assign result_word = (op_reg == OP_GET && stat_reg == STAT_OK)
                         ? WORD_W'(mem_rd_data) : '0;
    assign count_ext   = CMP_W'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (result_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cursor_reg <= cursor_next;
        if (accept)
        begin
            op_reg   <= in_op;
            stat_reg <= in_stat;
            pos_reg  <= in_addr;
            word_reg <= req.word_in[WORD_BITS-1:0];
        end
        if (result_load)
        begin
            out_word_reg <= result_word;
            out_stat_reg <= stat_reg;
            out_held_reg <= count_ext[HELD_W-1:0];
        end
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.word_out     = out_word_reg;
    assign rsp.status       = out_stat_reg;
    assign rsp.entries_held = out_held_reg;

endmodule

FILE: rtl/indexed_insert_erase_list.sv
// Top level of the indexed insert/erase list: sequencer plus entry store.
// Depends on iel_pkg, iel_if, iel_mem and iel_ctrl.
//
// A bounded ordered list of up to DEPTH words, kept in a single-port-write,
// single-port-read synchronous RAM with a registered read. Each request
// transaction carries an opcode (get, set, insert, erase, append, clear), a
// position and a word, and produces exactly one response transaction with
// the word read (zero unless a get succeeds), a status (ok, index out of
// range, store full) and the number of entries held after the operation. A
// failed operation leaves the list unchanged. The block works on one request
// at a time: req.ready is high only while the sequencer is idle, and a
// finished response waits in an output register so a new request can be
// taken while the previous response is still pending. Get, set, append,
// clear, failed requests, an insert at the end and an erase of the last
// entry go straight from idle to the finish state. Any other insert or erase
// shifts the later entries one place, and the RAM moves one entry per cycle:
// each move reads the neighbor and writes it back one place over in the
// following cycle, while the next read is already issued. An insert then
// writes the new word at its position. Words are stored as WORD_BITS bits
// and returned zero-extended; entries that were never written are never
// returned, since only positions below the count can be read.
module indexed_insert_erase_list #(
    parameter int DEPTH     = iel_pkg::DEPTH_DEF,
    parameter int WORD_BITS = iel_pkg::WORD_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    iel_req_if.sink   req,
    iel_rsp_if.source rsp
);
    import iel_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);

    logic                 mem_wr_en;
    logic [ADDR_W-1:0]    mem_wr_addr;
    logic [WORD_BITS-1:0] mem_wr_data;
    logic                 mem_rd_en;
    logic [ADDR_W-1:0]    mem_rd_addr;
    logic [WORD_BITS-1:0] mem_rd_data;

    // The sequencer owns the count, the shift cursor and the response register.
    iel_ctrl #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // The entry store has no reset; only written entries are ever read back.
    iel_mem #(
        .DEPTH (DEPTH),
        .WIDTH (WORD_BITS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

FILE: rtl/iel_checker.sv
// Port-level checks for the indexed insert/erase list, bound to the top level.
// Depends on iel_pkg and the iel_req_if / iel_rsp_if interfaces.
module iel_checker #(
    parameter int DEPTH = iel_pkg::DEPTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    iel_req_if.sink   req,
    iel_rsp_if.source rsp
);
    import iel_pkg::*;

    // A held response keeps its contents until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.word_out)
            && $stable(rsp.status) && $stable(rsp.entries_held))
        else $error("response changed while stalled");

    // One request at a time: a taken request blocks the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while another is in progress");

    // A nonzero word is returned only with an ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.word_out != '0 |-> rsp.status == STAT_OK)
        else $error("word returned with an error status");

    // A full-store refusal reports a full count.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == STAT_FULL |-> rsp.entries_held == HELD_W'(DEPTH))
        else $error("store full reported below capacity");

    // The status field never carries the unused code.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.status == STAT_OK || rsp.status == STAT_RANGE
            || rsp.status == STAT_FULL)
        else $error("undefined status code");

endmodule

bind indexed_insert_erase_list iel_checker #(.DEPTH(DEPTH)) u_iel_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
);
